>>> hw/rtl/mkpe_pkg.sv
// ----------------------------------------------------------------------------
// mkpe_pkg: shared types and constants of the mouse key pointer engine
// Action codes, register map, configuration record, multiplier handshake.
// ----------------------------------------------------------------------------
`default_nettype none

package mkpe_pkg;

   localparam int DELTA_W  = 8;
   localparam int STEP_W   = 8;
   localparam int CMD_W    = 5;
   localparam int MOVE_W   = 5;
   localparam int COORD_W  = 16;
   localparam int FRAC_W   = 4;
   localparam int MUL_W    = 8;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int CURVE_W  = 10;
   localparam int CNT_W    = $clog2(MUL_W);
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   typedef logic [1:0] action_type;
   localparam action_type ACT_MOVE   = 2'd0;
   localparam action_type ACT_WARP   = 2'd1;
   localparam action_type ACT_BUTTON = 2'd2;

   // warp command bit positions
   localparam int CMD_UP    = 0;
   localparam int CMD_DOWN  = 1;
   localparam int CMD_LEFT  = 2;
   localparam int CMD_RIGHT = 3;
   localparam int CMD_END   = 4;

   localparam logic [MUL_W-1:0] CURVE_MAX = 8'd255;

   typedef logic [2:0] reg_index_type;
   localparam reg_index_type REG_SPEED_LIMIT = 3'd0;
   localparam reg_index_type REG_ORIGIN_LEFT = 3'd1;
   localparam reg_index_type REG_ORIGIN_TOP  = 3'd2;
   localparam reg_index_type REG_FULL_WIDTH  = 3'd3;
   localparam reg_index_type REG_FULL_HEIGHT = 3'd4;

   localparam logic [7:0]         RST_SPEED_LIMIT = 8'd255;
   localparam logic [COORD_W-1:0] RST_ORIGIN      = 16'd0;
   localparam logic [COORD_W-1:0] RST_FULL_SIZE   = 16'd32767;

   typedef struct packed {
      logic [7:0]         speed_limit;
      logic [COORD_W-1:0] origin_left;
      logic [COORD_W-1:0] origin_top;
      logic [COORD_W-1:0] full_width;
      logic [COORD_W-1:0] full_height;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] product;
   } mul_rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/mkpe_req_if.sv
// ----------------------------------------------------------------------------
// mkpe_req_if: input channel of the pointer engine
// Valid/ready channel carrying one key action per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mkpe_req_if;
   import mkpe_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [1:0]                 action;
   logic signed [DELTA_W-1:0]  delta_x;
   logic signed [DELTA_W-1:0]  delta_y;
   logic [STEP_W-1:0]          accel_step;
   logic [CMD_W-1:0]           warp_command;

   modport source (
      output valid, action, delta_x, delta_y, accel_step, warp_command,
      input  ready
   );

   modport sink (
      input  valid, action, delta_x, delta_y, accel_step, warp_command,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/mkpe_rsp_if.sv
// ----------------------------------------------------------------------------
// mkpe_rsp_if: result channel of the pointer engine
// Valid/ready channel carrying one pointer report per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mkpe_rsp_if;
   import mkpe_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      report_kind;
   logic signed [MOVE_W-1:0]  move_x;
   logic signed [MOVE_W-1:0]  move_y;
   logic [COORD_W-1:0]        jump_x;
   logic [COORD_W-1:0]        jump_y;

   modport source (
      output valid, report_kind, move_x, move_y, jump_x, jump_y,
      input  ready
   );

   modport sink (
      input  valid, report_kind, move_x, move_y, jump_x, jump_y,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/mkpe_csr.sv
// ----------------------------------------------------------------------------
// mkpe_csr: configuration registers
// APB-style register file holding speed limit and full warp area.
// ----------------------------------------------------------------------------
`default_nettype none

module mkpe_csr
   import mkpe_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output logic      [CSR_DW-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign pready   = 1'b1;
   assign index    = paddr[CSR_AW-1:2];
   assign write_en = psel && penable && pwrite && pready;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_SPEED_LIMIT: cfg_in.speed_limit = pwdata[7:0];
            REG_ORIGIN_LEFT: cfg_in.origin_left = pwdata[COORD_W-1:0];
            REG_ORIGIN_TOP:  cfg_in.origin_top  = pwdata[COORD_W-1:0];
            REG_FULL_WIDTH:  cfg_in.full_width  = pwdata[COORD_W-1:0];
            REG_FULL_HEIGHT: cfg_in.full_height = pwdata[COORD_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_SPEED_LIMIT: prdata = {24'd0, cfg_ff.speed_limit};
         REG_ORIGIN_LEFT: prdata = {16'd0, cfg_ff.origin_left};
         REG_ORIGIN_TOP:  prdata = {16'd0, cfg_ff.origin_top};
         REG_FULL_WIDTH:  prdata = {16'd0, cfg_ff.full_width};
         REG_FULL_HEIGHT: prdata = {16'd0, cfg_ff.full_height};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_limit <= RST_SPEED_LIMIT;
         cfg_ff.origin_left <= RST_ORIGIN;
         cfg_ff.origin_top  <= RST_ORIGIN;
         cfg_ff.full_width  <= RST_FULL_SIZE;
         cfg_ff.full_height <= RST_FULL_SIZE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/mkpe_smul.sv
// ----------------------------------------------------------------------------
// mkpe_smul: bit-serial unsigned multiplier
// Shift-and-add, one multiplier bit per cycle, product ready after MUL_W steps.
// ----------------------------------------------------------------------------
`default_nettype none

module mkpe_smul
   import mkpe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire mul_req_type req,
   output mul_rsp_type      rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MUL_W-1:0]  a_ff, a_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [MUL_W:0]    partial;

   // upper half plus multiplicand when the current low bit is set
   assign partial = {1'b0, prod_ff[PROD_W-1:MUL_W]}
                  + (prod_ff[0] ? {1'b0, a_ff} : '0);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      prod_in = prod_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = req.a;
         prod_in = {{MUL_W{1'b0}}, req.b};
      end else if (busy_ff) begin
         prod_in = {partial, prod_ff[MUL_W-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MUL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff    <= a_in;
      prod_ff <= prod_in;
   end

   assign rsp.done    = done_ff;
   assign rsp.product = prod_ff;

endmodule

`default_nettype wire

>>> hw/rtl/mouse_key_pointer_engine.sv
// ----------------------------------------------------------------------------
// mouse_key_pointer_engine: keyboard-driven pointer engine
// Ease-curve relative moves with subpixel carry, and halving warp jumps.
// ----------------------------------------------------------------------------
// Usage: key actions enter on the req channel (valid/ready); each transfer is
// a move, a warp command or a button press. Reports leave on the rsp channel.
// A move always yields one relative report; a warp yields one absolute jump
// unless its end bit is set; a button press yields nothing.
// Configuration is written through the csr APB port; the user must do so only
// while the engine is idle, which the engine does not enforce. It takes one
// item at a time. A move runs four 8x8 products through one shared
// bit-serial multiplier (square, cube, x scale, y scale) plus curve and clamp
// steps; a warp halves the section and then takes its centre; a button press
// is handled on acceptance. The multiplier sets the move rate.
// The report sits in an output register; the next action is taken while it
// waits, and a finished item holds in its last step until the register frees.
// Reset (synchronous) restores the register defaults, ends warping and clears
// both subpixel remainders.
// ----------------------------------------------------------------------------
`default_nettype none

module mouse_key_pointer_engine
   import mkpe_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   mkpe_req_if.sink               req,
   mkpe_rsp_if.source             rsp,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   typedef enum logic [10:0] {
      S_IDLE = 11'b00000000001,
      S_SQ   = 11'b00000000010,
      S_CU   = 11'b00000000100,
      S_CRV  = 11'b00000001000,
      S_MX   = 11'b00000010000,
      S_AX   = 11'b00000100000,
      S_MY   = 11'b00001000000,
      S_AY   = 11'b00010000000,
      S_WARP = 11'b00100000000,
      S_CTR  = 11'b01000000000,
      S_OUT  = 11'b10000000000
   } state_type;

   cfg_type     cfg;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   mkpe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   mkpe_smul u_smul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   state_type                 state_ff, state_in;
   logic                      start_ff, start_in;
   logic                      kind_ff, kind_in;
   logic signed [DELTA_W-1:0] dx_ff, dx_in;
   logic signed [DELTA_W-1:0] dy_ff, dy_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [CMD_W-1:0]          cmd_ff, cmd_in;
   logic [MUL_W-1:0]          sq_ff, sq_in;
   logic [MUL_W-1:0]          cu_ff, cu_in;
   logic [MUL_W-1:0]          curve_ff, curve_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [MOVE_W-1:0]  mx_ff, mx_in;
   logic signed [MOVE_W-1:0]  my_ff, my_in;
   logic [FRAC_W-1:0]         rest_x_ff, rest_x_in;
   logic [FRAC_W-1:0]         rest_y_ff, rest_y_in;
   logic                      warping_ff, warping_in;
   logic [COORD_W-1:0]        left_ff, left_in;
   logic [COORD_W-1:0]        top_ff, top_in;
   logic [COORD_W-1:0]        width_ff, width_in;
   logic [COORD_W-1:0]        height_ff, height_in;
   logic [COORD_W-1:0]        jx_ff, jx_in;
   logic [COORD_W-1:0]        jy_ff, jy_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_kind_ff, rsp_kind_in;
   logic signed [MOVE_W-1:0]  rsp_mx_ff, rsp_mx_in;
   logic signed [MOVE_W-1:0]  rsp_my_ff, rsp_my_in;
   logic [COORD_W-1:0]        rsp_jx_ff, rsp_jx_in;
   logic [COORD_W-1:0]        rsp_jy_ff, rsp_jy_in;

   // axis datapath, shared by both axes
   logic                      axis_is_x;
   logic signed [DELTA_W-1:0] axis_d;
   logic [FRAC_W-1:0]         axis_rest;
   logic [MUL_W-1:0]          axis_mag;
   logic signed [SUM_W-1:0]   axis_prod;
   logic signed [SUM_W-1:0]   axis_sum;
   logic signed [SUM_W-1:0]   lim_pos;
   logic signed [SUM_W-1:0]   lim_neg;
   logic signed [SUM_W-1:0]   clamped;
   logic [CURVE_W-1:0]        curve_raw;
   logic [COORD_W-1:0]        half_w;
   logic [COORD_W-1:0]        half_h;
   logic                      out_free;

   assign axis_is_x = (state_ff == S_MX) || (state_ff == S_AX);
   assign axis_d    = axis_is_x ? dx_ff : dy_ff;
   assign axis_rest = axis_is_x ? rest_x_ff : rest_y_ff;
   assign axis_mag  = axis_d[DELTA_W-1] ? MUL_W'(-axis_d) : MUL_W'(axis_d);
   assign axis_prod = axis_d[DELTA_W-1] ? -$signed({1'b0, mul_rsp.product})
                                        :  $signed({1'b0, mul_rsp.product});
   assign axis_sum  = axis_prod + $signed({{(SUM_W-FRAC_W){1'b0}}, axis_rest});
   assign lim_pos   = $signed({{(SUM_W-8){1'b0}}, cfg.speed_limit});
   assign lim_neg   = -lim_pos;

   always_comb begin
      if (axis_d == '0) begin
         clamped = '0;
      end else if (sum_ff > lim_pos) begin
         clamped = lim_pos;
      end else if (sum_ff < lim_neg) begin
         clamped = lim_neg;
      end else begin
         clamped = sum_ff;
      end
   end

   assign curve_raw = ({2'b00, sq_ff} << 1) + {2'b00, sq_ff}
                    - ({2'b00, cu_ff} << 1) + CURVE_W'(1);

   assign half_w = width_ff  >> 1;
   assign half_h = height_ff >> 1;

   // multiplier operands follow the step that owns the product
   always_comb begin
      mul_req.start = start_ff;
      unique case (state_ff)
         S_SQ:    begin mul_req.a = step_ff;  mul_req.b = step_ff;  end
         S_CU:    begin mul_req.a = sq_ff;    mul_req.b = step_ff;  end
         S_MX,
         S_MY:    begin mul_req.a = axis_mag; mul_req.b = curve_ff; end
         default: begin mul_req.a = '0;       mul_req.b = '0;       end
      endcase
   end

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      start_in     = 1'b0;
      kind_in      = kind_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      step_in      = step_ff;
      cmd_in       = cmd_ff;
      sq_in        = sq_ff;
      cu_in        = cu_ff;
      curve_in     = curve_ff;
      sum_in       = sum_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      rest_x_in    = rest_x_ff;
      rest_y_in    = rest_y_ff;
      warping_in   = warping_ff;
      left_in      = left_ff;
      top_in       = top_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      jx_in        = jx_ff;
      jy_in        = jy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_mx_in    = rsp_mx_ff;
      rsp_my_in    = rsp_my_ff;
      rsp_jx_in    = rsp_jx_ff;
      rsp_jy_in    = rsp_jy_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               dx_in   = req.delta_x;
               dy_in   = req.delta_y;
               step_in = req.accel_step;
               cmd_in  = req.warp_command;
               case (req.action)
                  ACT_MOVE: begin
                     kind_in  = 1'b0;
                     start_in = 1'b1;
                     state_in = S_SQ;
                  end
                  ACT_WARP: begin
                     kind_in = 1'b1;
                     if (!warping_ff) begin
                        left_in   = cfg.origin_left;
                        top_in    = cfg.origin_top;
                        width_in  = cfg.full_width;
                        height_in = cfg.full_height;
                     end
                     if (req.warp_command[CMD_END]) begin
                        warping_in = 1'b0;
                     end else begin
                        warping_in = 1'b1;
                        state_in   = S_WARP;
                     end
                  end
                  ACT_BUTTON: warping_in = 1'b0;
                  default:    warping_in = warping_ff;
               endcase
            end
         end
         S_SQ: begin
            if (mul_rsp.done) begin
               sq_in    = mul_rsp.product[PROD_W-1:MUL_W];
               start_in = 1'b1;
               state_in = S_CU;
            end
         end
         S_CU: begin
            if (mul_rsp.done) begin
               cu_in    = mul_rsp.product[PROD_W-1:MUL_W];
               state_in = S_CRV;
            end
         end
         S_CRV: begin
            curve_in = (curve_raw > CURVE_W'(CURVE_MAX)) ? CURVE_MAX
                                                         : curve_raw[MUL_W-1:0];
            start_in = 1'b1;
            state_in = S_MX;
         end
         S_MX: begin
            if (mul_rsp.done) begin
               sum_in   = axis_sum;
               state_in = S_AX;
            end
         end
         S_AX: begin
            mx_in     = clamped[FRAC_W+MOVE_W-1:FRAC_W];
            rest_x_in = clamped[FRAC_W-1:0];
            start_in  = 1'b1;
            state_in  = S_MY;
         end
         S_MY: begin
            if (mul_rsp.done) begin
               sum_in   = axis_sum;
               state_in = S_AY;
            end
         end
         S_AY: begin
            my_in      = clamped[FRAC_W+MOVE_W-1:FRAC_W];
            rest_y_in  = clamped[FRAC_W-1:0];
            warping_in = 1'b0;
            state_in   = S_OUT;
         end
         S_WARP: begin
            width_in  = half_w;
            height_in = half_h;
            // up beats down, left beats right
            if (!cmd_ff[CMD_UP] && cmd_ff[CMD_DOWN]) begin
               top_in = top_ff + half_h;
            end
            if (!cmd_ff[CMD_LEFT] && cmd_ff[CMD_RIGHT]) begin
               left_in = left_ff + half_w;
            end
            state_in = S_CTR;
         end
         S_CTR: begin
            jx_in    = left_ff + half_w;
            jy_in    = top_ff + half_h;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_mx_in    = kind_ff ? '0 : mx_ff;
               rsp_my_in    = kind_ff ? '0 : my_ff;
               rsp_jx_in    = kind_ff ? jx_ff : '0;
               rsp_jy_in    = kind_ff ? jy_ff : '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         warping_ff   <= 1'b0;
         rest_x_ff    <= '0;
         rest_y_ff    <= '0;
         left_ff      <= '0;
         top_ff       <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         warping_ff   <= warping_in;
         rest_x_ff    <= rest_x_in;
         rest_y_ff    <= rest_y_in;
         left_ff      <= left_in;
         top_ff       <= top_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      step_ff     <= step_in;
      cmd_ff      <= cmd_in;
      sq_ff       <= sq_in;
      cu_ff       <= cu_in;
      curve_ff    <= curve_in;
      sum_ff      <= sum_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      jx_ff       <= jx_in;
      jy_ff       <= jy_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_mx_ff   <= rsp_mx_in;
      rsp_my_ff   <= rsp_my_in;
      rsp_jx_ff   <= rsp_jx_in;
      rsp_jy_ff   <= rsp_jy_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.report_kind = rsp_kind_ff;
   assign rsp.move_x      = rsp_mx_ff;
   assign rsp.move_y      = rsp_my_ff;
   assign rsp.jump_x      = rsp_jx_ff;
   assign rsp.jump_y      = rsp_jy_ff;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the mouse key pointer engine
// Drives key actions and register settings and keeps its own model of the
// ease-curve moves with subpixel carry and of the halving warp section. Every
// report is checked field by field against the oldest predicted one.
// ----------------------------------------------------------------------------

module tb_top;
   import mkpe_pkg::*;

   localparam action_type ACT_UNUSED = 2'd3;
   localparam logic [CMD_W-1:0] MASK_UP    = CMD_W'(1 << CMD_UP);
   localparam logic [CMD_W-1:0] MASK_DOWN  = CMD_W'(1 << CMD_DOWN);
   localparam logic [CMD_W-1:0] MASK_LEFT  = CMD_W'(1 << CMD_LEFT);
   localparam logic [CMD_W-1:0] MASK_RIGHT = CMD_W'(1 << CMD_RIGHT);
   localparam logic [CMD_W-1:0] MASK_END   = CMD_W'(1 << CMD_END);
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 64;

   typedef struct packed {
      action_type                action;
      logic signed [DELTA_W-1:0] delta_x;
      logic signed [DELTA_W-1:0] delta_y;
      logic [STEP_W-1:0]         accel_step;
      logic [CMD_W-1:0]          warp_command;
   } key_action_type;

   typedef struct packed {
      logic                     report_kind;
      logic signed [MOVE_W-1:0] move_x;
      logic signed [MOVE_W-1:0] move_y;
      logic [COORD_W-1:0]       jump_x;
      logic [COORD_W-1:0]       jump_y;
   } pointer_report_type;

   logic clock = 1'b0;
   logic reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   mkpe_req_if req_bus ();
   mkpe_rsp_if rsp_bus ();

   mouse_key_pointer_engine DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // engine model: register copy and pointer state
   cfg_type            csr_shadow;
   logic               warp_on;
   logic [COORD_W-1:0] sec_left, sec_top, sec_w, sec_h;
   logic [FRAC_W-1:0]  carry_x, carry_y;
   pointer_report_type pending_reports[$];

   int  mismatch_count = 0;
   int  items_sent = 0;
   int  cycle_count = 0;
   int  stall_left = 0;
   bit  calm = 1'b0;

   function automatic int unsigned ease_curve_of(input logic [STEP_W-1:0] step);
      int unsigned c, sq, cu, v;
      c  = step;
      sq = (c * c) >> 8;
      cu = (sq * c) >> 8;
      v  = 3 * sq - 2 * cu + 1;
      return (v > 255) ? 255 : v;
   endfunction

   // scaled axis plus carried fraction, clamped to the speed limit
   function automatic int clamp_axis(input logic signed [DELTA_W-1:0] d,
                                     input int unsigned curve,
                                     input logic [7:0] limit,
                                     inout logic [FRAC_W-1:0] carry);
      int s, lim;
      s   = 0;
      lim = int'(limit);
      if (d != 0) begin
         s = int'(carry) + int'(d) * int'(curve);
         if (s > lim) s = lim;
         else if (s < -lim) s = -lim;
      end
      carry = s[FRAC_W-1:0];
      return s;
   endfunction

   function automatic void predict_report(input key_action_type a);
      pointer_report_type r;
      int unsigned        curve;
      int                 sx, sy;
      r = '0;
      case (a.action)
         ACT_MOVE: begin
            curve = ease_curve_of(a.accel_step);
            sx = clamp_axis(a.delta_x, curve, csr_shadow.speed_limit, carry_x);
            sy = clamp_axis(a.delta_y, curve, csr_shadow.speed_limit, carry_y);
            warp_on = 1'b0;
            r.move_x = MOVE_W'(sx >>> FRAC_W);
            r.move_y = MOVE_W'(sy >>> FRAC_W);
            pending_reports.push_back(r);
         end
         ACT_WARP: begin
            if (!warp_on) begin
               sec_left = csr_shadow.origin_left;
               sec_top  = csr_shadow.origin_top;
               sec_w    = csr_shadow.full_width;
               sec_h    = csr_shadow.full_height;
               warp_on  = 1'b1;
            end
            if (a.warp_command[CMD_END]) begin
               warp_on = 1'b0;
            end else begin
               sec_w = sec_w >> 1;
               sec_h = sec_h >> 1;
               if (!a.warp_command[CMD_UP] && a.warp_command[CMD_DOWN])
                  sec_top = sec_top + sec_h;
               if (!a.warp_command[CMD_LEFT] && a.warp_command[CMD_RIGHT])
                  sec_left = sec_left + sec_w;
               r.report_kind = 1'b1;
               r.jump_x = sec_left + (sec_w >> 1);
               r.jump_y = sec_top + (sec_h >> 1);
               pending_reports.push_back(r);
            end
         end
         ACT_BUTTON: warp_on = 1'b0;
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : report_check
      pointer_report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_reports.size() == 0) begin
            $error("report transfer with none pending: kind %0d", rsp_bus.report_kind);
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("report_kind", want.report_kind, rsp_bus.report_kind);
            check_field("move_x", want.move_x, rsp_bus.move_x);
            check_field("move_y", want.move_y, rsp_bus.move_y);
            check_field("jump_x", want.jump_x, rsp_bus.jump_x);
            check_field("jump_y", want.jump_y, rsp_bus.jump_y);
         end
      end
   end

   // result side back-pressure in short random bursts
   always @(negedge clock) begin
      if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 5);
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic key_action_type random_fields();
      key_action_type a;
      a.action       = action_type'($urandom_range(0, 3));
      a.delta_x      = DELTA_W'($urandom);
      a.delta_y      = DELTA_W'($urandom);
      a.accel_step   = STEP_W'($urandom);
      a.warp_command = CMD_W'($urandom);
      return a;
   endfunction

   function automatic key_action_type move_action(input logic signed [DELTA_W-1:0] dx,
                                                  input logic signed [DELTA_W-1:0] dy,
                                                  input logic [STEP_W-1:0] step);
      key_action_type a;
      a            = random_fields();
      a.action     = ACT_MOVE;
      a.delta_x    = dx;
      a.delta_y    = dy;
      a.accel_step = step;
      return a;
   endfunction

   function automatic key_action_type warp_action(input logic [CMD_W-1:0] cmd);
      key_action_type a;
      a              = random_fields();
      a.action       = ACT_WARP;
      a.warp_command = cmd;
      return a;
   endfunction

   function automatic key_action_type plain_action(input action_type act);
      key_action_type a;
      a        = random_fields();
      a.action = act;
      return a;
   endfunction

   function automatic logic signed [DELTA_W-1:0] random_delta();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return $urandom_range(0, 1) ? DELTA_W'(1) : DELTA_W'(-1);
         2: return DELTA_W'($urandom_range(0, 8) - 4);
         default: return DELTA_W'($urandom);
      endcase
   endfunction

   function automatic logic [STEP_W-1:0] random_step();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return STEP_W'($urandom_range(0, 40));
         default: return STEP_W'($urandom);
      endcase
   endfunction

   task automatic send_action(input key_action_type a);
      int gap;
      @(negedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         gap = $urandom_range(1, 5);
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= a.action;
      req_bus.delta_x      <= a.delta_x;
      req_bus.delta_y      <= a.delta_y;
      req_bus.accel_step   <= a.accel_step;
      req_bus.warp_command <= a.warp_command;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_report(a);
      if (a.action != ACT_UNUSED) items_sent++;
   endtask

   // stop sending, let every pending report arrive and the engine go quiet
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_DW-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_SPEED_LIMIT: csr_shadow.speed_limit = value[7:0];
         REG_ORIGIN_LEFT: csr_shadow.origin_left = value[COORD_W-1:0];
         REG_ORIGIN_TOP:  csr_shadow.origin_top  = value[COORD_W-1:0];
         REG_FULL_WIDTH:  csr_shadow.full_width  = value[COORD_W-1:0];
         REG_FULL_HEIGHT: csr_shadow.full_height = value[COORD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [7:0] speed,
                                 input logic [COORD_W-1:0] left, top, width, height);
      csr_write(REG_SPEED_LIMIT, CSR_DW'(speed));
      csr_write(REG_ORIGIN_LEFT, CSR_DW'(left));
      csr_write(REG_ORIGIN_TOP, CSR_DW'(top));
      csr_write(REG_FULL_WIDTH, CSR_DW'(width));
      csr_write(REG_FULL_HEIGHT, CSR_DW'(height));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_warp_burst();
      int n;
      n = $urandom_range(1, 8);
      repeat (n) send_action(warp_action(CMD_W'($urandom_range(0, 15))));
      case ($urandom_range(0, 3))
         0: send_action(warp_action(CMD_W'($urandom_range(16, 31))));
         1: send_action(plain_action(ACT_BUTTON));
         2: send_action(move_action(random_delta(), random_delta(), random_step()));
         default: ;  // leave the section open for the next burst
      endcase
   endtask

   task automatic run_random_traffic(input int count);
      int target, n;
      target = items_sent + count;
      while (items_sent < target) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: begin
               n = $urandom_range(1, 6);
               repeat (n) send_action(move_action(random_delta(), random_delta(),
                                                  random_step()));
            end
            9, 10, 11, 12, 13, 14, 15, 16: run_warp_burst();
            default: send_action(random_fields());
         endcase
      end
   endtask

   task automatic test_move_directed();
      send_action(move_action(8'sd0, 8'sd0, 8'd0));
      send_action(move_action(8'sd127, -8'sd128, 8'd255));
      send_action(move_action(8'sd1, -8'sd1, 8'd0));
      send_action(move_action(8'sd1, -8'sd1, 8'd0));
      send_action(move_action(8'sd0, 8'sd5, 8'd128));
      send_action(move_action(-8'sd128, 8'sd127, 8'd128));
      send_action(move_action(-8'sd1, 8'sd1, 8'd1));
      send_action(plain_action(ACT_UNUSED));
      send_action(move_action(8'sd7, 8'sd0, 8'd200));
   endtask

   task automatic test_warp_directed();
      send_action(warp_action('0));
      send_action(warp_action(MASK_DOWN | MASK_RIGHT));
      send_action(warp_action(MASK_UP | MASK_DOWN | MASK_LEFT | MASK_RIGHT));
      send_action(warp_action(MASK_UP | MASK_LEFT));
      send_action(warp_action(MASK_END));
      // end bit while idle still loads the section first
      send_action(warp_action(MASK_END));
      send_action(warp_action(MASK_DOWN));
      send_action(plain_action(ACT_BUTTON));
      send_action(warp_action(MASK_RIGHT));
      send_action(move_action(8'sd3, -8'sd2, 8'd60));
      send_action(warp_action('1));
      send_action(warp_action(MASK_LEFT | MASK_DOWN));
      send_action(plain_action(ACT_UNUSED));
      send_action(warp_action(MASK_UP | MASK_RIGHT));
   endtask

   task automatic test_register_sweep();
      for (int phase = 0; phase < 6; phase++) begin
         settle();
         case (phase)
            0: apply_settings(8'd255, 16'd0, 16'd0, 16'd32767, 16'd32767);
            1: apply_settings(8'd0, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
            2: apply_settings(8'd1, 16'd0, 16'd0, 16'd0, 16'd0);
            3: apply_settings(8'd255, 16'hffff, 16'd0, 16'd1, 16'hffff);
            default: apply_settings(8'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom), 16'($urandom));
         endcase
         run_random_traffic(115);
      end
   endtask

   task automatic test_steady_stream();
      settle();
      apply_settings(8'($urandom_range(16, 255)), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
      calm = 1'b1;
      run_random_traffic(80);
   endtask

   initial begin
      csr_shadow.speed_limit = RST_SPEED_LIMIT;
      csr_shadow.origin_left = RST_ORIGIN;
      csr_shadow.origin_top  = RST_ORIGIN;
      csr_shadow.full_width  = RST_FULL_SIZE;
      csr_shadow.full_height = RST_FULL_SIZE;
      warp_on  = 1'b0;
      sec_left = '0;
      sec_top  = '0;
      sec_w    = '0;
      sec_h    = '0;
      carry_x  = '0;
      carry_y  = '0;

      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.action       <= ACT_MOVE;
      req_bus.delta_x      <= '0;
      req_bus.delta_y      <= '0;
      req_bus.accel_step   <= '0;
      req_bus.warp_command <= '0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_move_directed();
      test_warp_directed();
      test_register_sweep();
      test_steady_stream();
      settle();

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/mkpe_pkg.sv
hw/rtl/mkpe_req_if.sv
hw/rtl/mkpe_rsp_if.sv
hw/rtl/mkpe_csr.sv
hw/rtl/mkpe_smul.sv
hw/rtl/mouse_key_pointer_engine.sv
tb/tb_top.sv
